// File: hw/rtl/jek_pkg.sv
// Shared types and constants for the joystick event to key translator.
// No dependencies; imported by joystick_event_to_key and its test bench.
package jek_pkg;

  // Request payload: one joystick event.
  typedef struct packed {
    logic [7:0]         event_type;
    logic [7:0]         event_number;
    logic signed [15:0] event_value;
  } event_t;

  // Result payload: one key report.
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] key_group;
    logic [7:0] key_number;
    logic       key_down;
  } key_t;

  localparam logic [1:0] ST_NOTHING = 2'd0;
  localparam logic [1:0] ST_KEY     = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  localparam logic [1:0] ZONE_CENTRE = 2'd0;
  localparam logic [1:0] ZONE_PLUS   = 2'd1;
  localparam logic [1:0] ZONE_MINUS  = 2'd2;

  localparam logic [1:0] GROUP_BUTTON = 2'd0;

  localparam int TYPE_BUTTON_BIT = 0;
  localparam int TYPE_AXIS_BIT   = 1;
  localparam int TYPE_INIT_BIT   = 7;
  localparam logic [6:0] TYPE_BUTTON_ONLY = 7'h01;

  localparam logic [14:0] THRESHOLD_RESET = 15'd500;

  localparam int          PADDR_W      = 3;
  localparam logic [0:0]  REG_THRESHOLD = 1'b0;

endpackage

// File: hw/rtl/jek_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jek_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/joystick_event_to_key.sv
// Joystick event to key translator: one event in, one key report out.
// Pipeline: the event register, then the result register; takes one event per cycle
// while key_stall does not hold the result register, set by the single
// read port of the axis zone RAM, with a bypass for back-to-back same-axis events.
// Reset: button levels clear, all axes read as centre (valid bits), threshold 500.
// Depends on jek_pkg and jek_ram.
module joystick_event_to_key #(
  parameter int AXES    = 256,
  parameter int BUTTONS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jek_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  jek_pkg::event_t               ev,
  input  logic                          ev_valid,
  output logic                          ev_stall,
  output jek_pkg::key_t                 key,
  output logic                          key_valid,
  input  logic                          key_stall
);

  import jek_pkg::*;

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int BTW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  // Configuration
  logic [14:0] threshold;
  logic        cfg_write;
  logic        cfg_hit;

  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[PADDR_W-1 -: 1] == REG_THRESHOLD);
  assign cfg_write = psel && penable && pwrite && cfg_hit;
  assign prdata    = cfg_hit ? {17'd0, threshold} : 32'd0;

  // Pipeline control
  logic   s1_valid;
  event_t s1;
  logic   advance;
  logic   ev_take;

  assign advance  = !key_valid || !key_stall;
  assign ev_stall = s1_valid && !advance;
  assign ev_take  = ev_valid && !ev_stall;

  // State
  logic [BUTTONS-1:0] button_levels;
  logic [BUTTONS-1:0] button_levels_next;
  logic [AXES-1:0]    zone_valid;
  logic [1:0]         ram_q;
  logic               bypass_hit;
  logic [1:0]         bypass_zone;

  // Stage-1 decode
  logic [6:0]         typ;
  logic               init;
  logic [AXW-1:0]     aidx;
  logic [BTW-1:0]     bidx;
  logic               btn_ok;
  logic               axis_ok;
  logic               stored_bit;
  logic               new_level;
  logic [1:0]         old_zone;
  logic [1:0]         new_zone;
  logic signed [16:0] val_ext;
  logic signed [16:0] thr_ext;
  logic               zone_we;
  key_t               res;

  assign typ      = s1.event_type[6:0];
  assign init     = s1.event_type[TYPE_INIT_BIT];
  assign aidx     = s1.event_number[AXW-1:0];
  assign bidx     = s1.event_number[BTW-1:0];
  assign btn_ok   = ({1'b0, s1.event_number} < 9'(BUTTONS));
  assign axis_ok  = ({1'b0, s1.event_number} < 9'(AXES));
  assign val_ext  = {s1.event_value[15], s1.event_value};
  assign thr_ext  = {2'b00, threshold};

  always_comb begin
    stored_bit = button_levels[bidx];
    new_level  = (s1.event_value == 16'sd1);
    if (bypass_hit) begin
      old_zone = bypass_zone;
    end else if (zone_valid[aidx]) begin
      old_zone = ram_q;
    end else begin
      old_zone = ZONE_CENTRE;
    end
    if (val_ext > thr_ext) begin
      new_zone = ZONE_PLUS;
    end else if (val_ext < -thr_ext) begin
      new_zone = ZONE_MINUS;
    end else begin
      new_zone = ZONE_CENTRE;
    end
  end

  always_comb begin
    res                = '0;
    res.status         = ST_ERROR;
    button_levels_next = button_levels;
    zone_we            = 1'b0;
    if (typ[TYPE_BUTTON_BIT]) begin
      if (btn_ok) begin
        // Drop an init event that matches the stored level.
        if (init && typ == TYPE_BUTTON_ONLY &&
            s1.event_value == {15'd0, stored_bit}) begin
          res.status = ST_NOTHING;
        end else begin
          button_levels_next[bidx] = new_level;
          res.status     = ST_KEY;
          res.key_group  = GROUP_BUTTON;
          res.key_number = s1.event_number;
          res.key_down   = new_level;
        end
      end
    end else if (typ[TYPE_AXIS_BIT]) begin
      if (axis_ok) begin
        if (new_zone == old_zone) begin
          res.status = ST_NOTHING;
        end else begin
          zone_we        = 1'b1;
          res.status     = ST_KEY;
          res.key_number = s1.event_number;
          if (new_zone == ZONE_CENTRE) begin
            res.key_group = old_zone;
            res.key_down  = 1'b0;
          end else begin
            res.key_group = new_zone;
            res.key_down  = 1'b1;
          end
        end
      end
    end
  end

  logic zone_wr;
  assign zone_wr = s1_valid && advance && zone_we;

  jek_ram #(
    .WIDTH (2),
    .DEPTH (AXES)
  ) u_zone_ram (
    .clk   (clk),
    .we    (zone_wr),
    .waddr (aidx),
    .wdata (new_zone),
    .re    (ev_take),
    .raddr (ev.event_number[AXW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RESET;
      s1_valid      <= 1'b0;
      key_valid     <= 1'b0;
      button_levels <= '0;
      zone_valid    <= '0;
      bypass_hit    <= 1'b0;
    end else begin
      if (cfg_write) begin
        threshold <= pwdata[14:0];
      end
      if (ev_take) begin
        s1_valid <= 1'b1;
        // The RAM read misses a write to the same axis in this cycle: forward it.
        bypass_hit <= zone_wr && (aidx == ev.event_number[AXW-1:0]);
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        key_valid <= s1_valid;
      end
      if (s1_valid && advance) begin
        button_levels <= button_levels_next;
        if (zone_we) begin
          zone_valid[aidx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take) begin
      s1          <= ev;
      bypass_zone <= new_zone;
    end
    if (advance) begin
      key <= res;
    end
  end

endmodule

// File: tb/sv/joystick_event_to_key_test.sv
// Self-checking bench for joystick_event_to_key: directed and random joystick events,
// a local translator that predicts each key report, and APB writes of the axis threshold.
// Depends on jek_pkg and the joystick_event_to_key RTL.
module joystick_event_to_key_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jek_pkg::*;

  localparam int AXES_N         = 256;
  localparam int BUTTONS_N      = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = PADDR_W'(REG_THRESHOLD) << 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  event_t      ev = '0;
  logic        ev_valid = 1'b0;
  logic        ev_stall;
  key_t        key;
  logic        key_valid;
  logic        key_stall = 1'b0;

  joystick_event_to_key #(
    .AXES    (AXES_N),
    .BUTTONS (BUTTONS_N)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .ev        (ev),
    .ev_valid  (ev_valid),
    .ev_stall  (ev_stall),
    .key       (key),
    .key_valid (key_valid),
    .key_stall (key_stall)
  );

  // Translator state mirrored from the block.
  logic [BUTTONS_N-1:0] button_level_q;
  logic [1:0]           axis_zone_q [AXES_N];
  logic [14:0]          threshold_q;

  event_t      event_queue [$];
  key_t        key_queue [$];
  int unsigned events_queued = 0;
  int unsigned events_taken = 0;
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_armed = 1'b0;
  bit          hold_used;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [1:0] zone_for(input logic signed [15:0] value);
    int thr;
    int pos;
    thr = int'(threshold_q);
    pos = int'(value);
    if (pos > thr) return ZONE_PLUS;
    if (pos < -thr) return ZONE_MINUS;
    return ZONE_CENTRE;
  endfunction

  task automatic translate_event(input event_t e);
    key_t       k;
    logic [6:0] kind;
    bit         init;
    bit         level;
    logic [1:0] old_zone;
    logic [1:0] new_zone;
    k = '0;
    init = e.event_type[TYPE_INIT_BIT];
    kind = e.event_type[6:0];
    if (kind[TYPE_BUTTON_BIT]) begin
      if (int'(e.event_number) >= BUTTONS_N) begin
        k.status = ST_ERROR;
      end else if (init && kind == TYPE_BUTTON_ONLY &&
                   int'(e.event_value) == int'(button_level_q[e.event_number])) begin
        k.status = ST_NOTHING;
      end else begin
        level = (e.event_value == 16'sd1);
        button_level_q[e.event_number] = level;
        k.status     = ST_KEY;
        k.key_group  = GROUP_BUTTON;
        k.key_number = e.event_number;
        k.key_down   = level;
      end
    end else if (kind[TYPE_AXIS_BIT]) begin
      if (int'(e.event_number) >= AXES_N) begin
        k.status = ST_ERROR;
      end else begin
        old_zone = axis_zone_q[e.event_number];
        new_zone = zone_for(e.event_value);
        if (new_zone != old_zone) begin
          axis_zone_q[e.event_number] = new_zone;
          k.status     = ST_KEY;
          k.key_number = e.event_number;
          if (new_zone == ZONE_CENTRE) begin
            k.key_group = old_zone;
            k.key_down  = 1'b0;
          end else begin
            k.key_group = new_zone;
            k.key_down  = 1'b1;
          end
        end
      end
    end else begin
      k.status = ST_ERROR;
    end
    key_queue.push_back(k);
  endtask

  // Request driver: hold a stalled request, else offer the next event or idle.
  always @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      if (ev_valid && !ev_stall) begin
        translate_event(ev);
        events_taken++;
      end
      if (!(ev_valid && ev_stall)) begin
        if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev       <= event_queue.pop_front();
          ev_valid <= 1'b1;
        end else begin
          ev_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once when armed.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Key monitor: compare each accepted report with the oldest prediction.
  always @(posedge clk) begin
    key_t exp_key;
    if (rst) begin
      key_stall <= 1'b0;
    end else begin
      if (key_valid && !key_stall) begin
        if (key_queue.size() == 0) begin
          note_failure($sformatf("unexpected key report st=%0d grp=%0d num=%0d down=%0d",
                                 key.status, key.key_group, key.key_number, key.key_down));
        end else begin
          exp_key = key_queue.pop_front();
          if (key.status !== exp_key.status || key.key_group !== exp_key.key_group ||
              key.key_number !== exp_key.key_number || key.key_down !== exp_key.key_down) begin
            note_failure($sformatf(
              "key mismatch: expected st=%0d grp=%0d num=%0d down=%0d, got st=%0d grp=%0d num=%0d down=%0d",
              exp_key.status, exp_key.key_group, exp_key.key_number, exp_key.key_down,
              key.status, key.key_group, key.key_number, key.key_down));
          end
        end
      end
      key_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((ev_valid && !ev_stall) || (key_valid && !key_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("joystick_event_to_key_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_event(input logic [7:0] kind, input logic [7:0] num,
                           input logic signed [15:0] value);
    event_t e;
    e.event_type   = kind;
    e.event_number = num;
    e.event_value  = value;
    event_queue.push_back(e);
    events_queued++;
  endtask

  function automatic event_t rand_event();
    event_t      e;
    int unsigned pick;
    int          v;
    pick = $urandom_range(99);
    e.event_value  = 16'($urandom);
    e.event_number = 8'($urandom_range(7));
    if ($urandom_range(9) == 0) e.event_number = 8'($urandom);
    if (pick < 40) begin
      e.event_type   = 8'h01;
      e.event_number = 8'($urandom_range(BUTTONS_N - 1));
      if ($urandom_range(9) == 0) e.event_number = 8'($urandom);
      if ($urandom_range(9) != 0) e.event_value = 16'($urandom_range(1));
    end else if (pick < 85) begin
      e.event_type = 8'h02;
      case ($urandom_range(3))
        0: v = int'(threshold_q) + int'($urandom_range(2)) - 1;
        1: v = -int'(threshold_q) + int'($urandom_range(2)) - 1;
        2: v = int'($urandom_range(20)) - 10;
        default: v = int'($signed(16'($urandom)));
      endcase
      e.event_value = 16'(v);
    end else if (pick < 93) begin
      // junk in the unused type bits, with the axis bit always set
      e.event_type = 8'($urandom) | 8'h02;
    end else begin
      e.event_type   = 8'($urandom);
      e.event_number = 8'($urandom);
    end
    if (pick < 85 && $urandom_range(3) == 0) e.event_type[TYPE_INIT_BIT] = 1'b1;
    return e;
  endfunction

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_THRESHOLD) threshold_q = data[14:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every event is taken and every report has come back.
  task automatic drain();
    while (events_taken != events_queued) @(posedge clk);
    while (key_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [14:0] thr, input int unsigned send_pct,
                           input int unsigned recv_pct, input int count, input bit hold);
    apb_write(ADDR_THRESHOLD, {17'($urandom), thr});
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) hold_armed = 1'b1;
    for (int i = 0; i < count; i++) event_queue.push_back(rand_event());
    events_queued += count;
    drain();
  endtask

  initial begin
    button_level_q = '0;
    for (int a = 0; a < AXES_N; a++) axis_zone_q[a] = ZONE_CENTRE;
    threshold_q = THRESHOLD_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed events at the reset threshold.
    add_event(8'h01, 8'd0, 16'sd1);
    add_event(8'h01, 8'd31, 16'sd1);
    add_event(8'h01, 8'd31, 16'sd0);
    add_event(8'h01, 8'd5, 16'sd1);
    add_event(8'h01, 8'd5, -16'sd32768);
    add_event(8'h01, 8'd5, 16'sd32767);
    add_event(8'h01, 8'd32, 16'sd1);
    add_event(8'h01, 8'd255, 16'sd0);
    add_event(8'h81, 8'd0, 16'sd1);
    add_event(8'h81, 8'd1, 16'sd1);
    add_event(8'h81, 8'd1, 16'sd2);
    add_event(8'h03, 8'd2, 16'sd1);
    add_event(8'h83, 8'd2, 16'sd1);
    add_event(8'h00, 8'd0, 16'sd0);
    add_event(8'h80, 8'd3, 16'sd0);
    add_event(8'hFC, 8'hAA, 16'shAAAA);
    add_event(8'h02, 8'd0, 16'sd32767);
    add_event(8'h02, 8'd0, 16'sd501);
    add_event(8'h02, 8'd0, 16'sd500);
    add_event(8'h02, 8'd0, -16'sd501);
    add_event(8'h02, 8'd0, 16'sd32767);
    add_event(8'h02, 8'd255, -16'sd32768);
    add_event(8'h02, 8'd255, -16'sd500);
    add_event(8'h82, 8'd7, 16'sd0);
    add_event(8'h82, 8'd7, 16'sd1000);
    add_event(8'h81, 8'd9, 16'sd0);
    drain();

    run_phase(15'd0, 0, 0, 90, 1'b0);
    run_phase(15'd32767, 71, 0, 70, 1'b0);
    run_phase(15'd500, 0, 71, 90, 1'b1);
    run_phase(15'($urandom), 25, 25, 90, 1'b0);
    run_phase(15'($urandom_range(40, 1)), 0, 0, 90, 1'b0);

    if (fail_count == 0) begin
      $display("joystick_event_to_key_test passed");
    end else begin
      $display("joystick_event_to_key_test failed");
    end
    $finish;
  end

endmodule
